@@ rtl/pgeo_pkg.sv @@
// ----------------------------------------------------------------------------
// pgeo_pkg
// Constants, types and helpers shared by the geodesic pipeline.
// ----------------------------------------------------------------------------
package pgeo_pkg;

  localparam int FRAC_BITS = 14;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 32;

  // Numerator holds up to about 2^50 in magnitude; after the Q16 lift it needs 67 bits.
  localparam int NUM_W  = 68;
  localparam int DEN_W  = 33 + FRAC_BITS + 1;
  localparam int QUO_W  = 48;
  localparam int REM_W  = DEN_W + 1;
  localparam int SQ_W   = 96;
  localparam int ROOT_W = 48;

  localparam logic [1:0] KIND_CIRCLE = 2'd0;
  localparam logic [1:0] KIND_LINE   = 2'd1;
  localparam logic [1:0] KIND_DEGEN  = 2'd2;

  typedef logic signed [IN_W-1:0]  coord_t;
  typedef logic signed [OUT_W-1:0] value_t;

  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[OUT_W-1:0];
    end
  endfunction

  // Convert an input-format value to Q16.16, half away from zero.
  function automatic logic signed [63:0] to_q16(input logic signed [63:0] v);
    logic [63:0] m;
    if (FRAC_BITS <= 16) begin
      return v <<< (16 - FRAC_BITS);
    end else begin
      m = (v < 0) ? 64'(-v) : 64'(v);
      m = (m + (64'd1 << (FRAC_BITS - 17))) >> (FRAC_BITS - 16);
      return (v < 0) ? -$signed(m) : $signed(m);
    end
  endfunction

endpackage

@@ rtl/pgeo_div.sv @@
// ----------------------------------------------------------------------------
// pgeo_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with
// rounding to nearest (ties up) at the last stage.
// ----------------------------------------------------------------------------
module pgeo_div
  import pgeo_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic [QUO_W:0]    quo
);

  logic [NUM_W-1:0] n_s [QUO_W+1];
  logic [DEN_W-1:0] d_s [QUO_W+1];
  logic [REM_W-1:0] r_s [QUO_W+1];
  logic [QUO_W-1:0] q_s [QUO_W+1];
  logic             ov_s [QUO_W+1];

  // Seed the remainder with the top NUM_W-QUO_W bits; flag a quotient that
  // does not fit in QUO_W bits and force it to all ones.
  always_comb begin
    n_s[0]  = num;
    d_s[0]  = den;
    r_s[0]  = REM_W'(num[NUM_W-1:QUO_W]);
    q_s[0]  = '0;
    ov_s[0] = (DEN_W'(num[NUM_W-1:QUO_W]) >= den);
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_st
    logic [REM_W:0] t;
    logic [REM_W:0] sub;
    always_comb begin
      t   = {r_s[i], n_s[i][QUO_W-1-i]};
      sub = t - {2'b0, d_s[i]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_s[i+1]  <= n_s[i];
        d_s[i+1]  <= d_s[i];
        ov_s[i+1] <= ov_s[i];
        if (!sub[REM_W]) begin
          r_s[i+1] <= sub[REM_W-1:0];
          q_s[i+1] <= {q_s[i][QUO_W-2:0], 1'b1};
        end else begin
          r_s[i+1] <= t[REM_W-1:0];
          q_s[i+1] <= {q_s[i][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  logic [REM_W:0] twice;
  always_comb begin
    twice = {r_s[QUO_W], 1'b0};
    if (ov_s[QUO_W]) begin
      quo = '1;
    end else begin
      quo = {1'b0, q_s[QUO_W]} + ((twice >= {2'b0, d_s[QUO_W]}) ? 1'b1 : 1'b0);
    end
  end

endmodule

@@ rtl/poincare_geodesic_through_two_points_top.sv @@
// ----------------------------------------------------------------------------
// poincare_geodesic_through_two_points_top
// Hyperbolic line through two points of the Poincare disk.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle; a stall freezes the whole pipeline.
// The divider and square-root ladders set the depth, one bit per stage.
// Reset clears the valid bits only; payload registers are not reset.
module poincare_geodesic_through_two_points_top
  import pgeo_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,  // first_x, first_y, second_x, second_y
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,  // value_one, value_two, value_three
  output logic [1:0]   m_tuser   // kind
);

  localparam int DEPTH = QUO_W + ROOT_W + 8;

  logic en;
  logic [DEPTH-1:0] vld;
  assign en       = !vld[DEPTH-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], s_tvalid};
    end
  end

  // stage 1: capture and products
  coord_t ax1, ay1, bx1, by1;
  logic signed [31:0] p_axby, p_bxay, p_axax, p_ayay, p_bxbx, p_byby;
  always_ff @(posedge clk) begin
    if (en) begin
      ax1 <= s_tdata[15:0];  ay1 <= s_tdata[31:16];
      bx1 <= s_tdata[47:32]; by1 <= s_tdata[63:48];
      p_axby <= $signed(s_tdata[15:0])  * $signed(s_tdata[63:48]);
      p_bxay <= $signed(s_tdata[47:32]) * $signed(s_tdata[31:16]);
      p_axax <= $signed(s_tdata[15:0])  * $signed(s_tdata[15:0]);
      p_ayay <= $signed(s_tdata[31:16]) * $signed(s_tdata[31:16]);
      p_bxbx <= $signed(s_tdata[47:32]) * $signed(s_tdata[47:32]);
      p_byby <= $signed(s_tdata[63:48]) * $signed(s_tdata[63:48]);
    end
  end

  // stage 2: d, pa, pb, classify
  coord_t ax2, ay2, bx2, by2;
  logic signed [33:0] d2;
  logic [33:0] pa2, pb2;
  logic [1:0] kind2;
  always_ff @(posedge clk) begin
    if (en) begin
      ax2 <= ax1; ay2 <= ay1; bx2 <= bx1; by2 <= by1;
      d2  <= 34'(p_axby) - 34'(p_bxay);
      pa2 <= (34'd1 << (2*FRAC_BITS)) + 34'(unsigned'(p_axax)) + 34'(unsigned'(p_ayay));
      pb2 <= (34'd1 << (2*FRAC_BITS)) + 34'(unsigned'(p_bxbx)) + 34'(unsigned'(p_byby));
      if (ax1 == bx1 && ay1 == by1) kind2 <= KIND_DEGEN;
      else if (p_axby == p_bxay)   kind2 <= KIND_LINE;
      else                          kind2 <= KIND_CIRCLE;
    end
  end

  // stage 3: numerator products
  logic signed [51:0] m1x, m2x, m1y, m2y;
  coord_t ax3, ay3, bx3, by3;
  logic signed [33:0] d3;
  logic [1:0] kind3;
  always_ff @(posedge clk) begin
    if (en) begin
      m1x <= $signed({18'd0, pa2}) * 52'(by2);
      m2x <= $signed({18'd0, pb2}) * 52'(ay2);
      m1y <= $signed({18'd0, pb2}) * 52'(ax2);
      m2y <= $signed({18'd0, pa2}) * 52'(bx2);
      ax3 <= ax2; ay3 <= ay2; bx3 <= bx2; by3 <= by2;
      d3 <= d2; kind3 <= kind2;
    end
  end

  // stage 4: magnitudes into the divider, signs into the side line
  logic [NUM_W-1:0] nx4, ny4;
  logic [DEN_W-1:0] den4;
  logic signed [52:0] nx_c, ny_c;
  always_comb begin
    nx_c = 53'(m1x) - 53'(m2x);
    ny_c = 53'(m1y) - 53'(m2y);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      nx4  <= NUM_W'(nx_c[52] ? 53'(-nx_c) : 53'(nx_c)) << 16;
      ny4  <= NUM_W'(ny_c[52] ? 53'(-ny_c) : 53'(ny_c)) << 16;
      den4 <= DEN_W'(d3[33] ? 34'(-d3) : 34'(d3)) << (FRAC_BITS + 1);
    end
  end

  logic [QUO_W:0] qx, qy;
  pgeo_div u_divx (.clk(clk), .en(en), .num(nx4), .den(den4), .quo(qx));
  pgeo_div u_divy (.clk(clk), .en(en), .num(ny4), .den(den4), .quo(qy));

  // side line for fields not needed by the divider
  localparam int SL = QUO_W + 1;
  coord_t sax [SL], say [SL], sbx [SL], sby [SL];
  logic [1:0] skd [SL];
  logic ssx [SL], ssy [SL];
  always_ff @(posedge clk) begin
    if (en) begin
      sax[0] <= ax3; say[0] <= ay3; sbx[0] <= bx3; sby[0] <= by3;
      skd[0] <= kind3; ssx[0] <= nx_c[52] ^ d3[33]; ssy[0] <= ny_c[52] ^ d3[33];
      for (int i = 1; i < SL; i++) begin
        sax[i] <= sax[i-1]; say[i] <= say[i-1]; sbx[i] <= sbx[i-1];
        sby[i] <= sby[i-1]; skd[i] <= skd[i-1]; ssx[i] <= ssx[i-1]; ssy[i] <= ssy[i-1];
      end
    end
  end

  // stage 5: signed centre and differences
  logic signed [63:0] ox5, oy5, dx5, dy5;
  logic [1:0] kind5;
  value_t la5, lb5;
  logic signed [63:0] oxs, oys;
  always_comb begin
    oxs = ssx[SL-1] ? -$signed(64'(qx)) : $signed(64'(qx));
    oys = ssy[SL-1] ? -$signed(64'(qy)) : $signed(64'(qy));
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ox5 <= oxs; oy5 <= oys;
      dx5 <= oxs - to_q16(64'(sax[SL-1]));
      dy5 <= oys - to_q16(64'(say[SL-1]));
      la5 <= sat32(to_q16(64'(say[SL-1]) - 64'(sby[SL-1])));
      lb5 <= sat32(to_q16(64'(sbx[SL-1]) - 64'(sax[SL-1])));
      kind5 <= skd[SL-1];
    end
  end

  // stage 6: squares (clamp magnitudes to 47 bits; split into halves)
  logic [63:0] mx, my;
  logic [47:0] ux, uy;
  assign mx = dx5[63] ? 64'(-dx5) : 64'(dx5);
  assign my = dy5[63] ? 64'(-dy5) : 64'(dy5);
  assign ux = (mx[63:47] != '0) ? 48'h7FFFFFFFFFFF : mx[47:0];
  assign uy = (my[63:47] != '0) ? 48'h7FFFFFFFFFFF : my[47:0];
  logic [SQ_W-1:0] sqx_ll, sqx_hl, sqx_hh, sqy_ll, sqy_hl, sqy_hh;
  value_t o1_6, o2_6, la6, lb6;
  logic [1:0] kind6;
  always_ff @(posedge clk) begin
    if (en) begin
      sqx_ll <= SQ_W'(48'(ux[23:0]) * 48'(ux[23:0]));
      sqx_hl <= SQ_W'(48'(ux[47:24]) * 48'(ux[23:0]));
      sqx_hh <= SQ_W'(48'(ux[47:24]) * 48'(ux[47:24]));
      sqy_ll <= SQ_W'(48'(uy[23:0]) * 48'(uy[23:0]));
      sqy_hl <= SQ_W'(48'(uy[47:24]) * 48'(uy[23:0]));
      sqy_hh <= SQ_W'(48'(uy[47:24]) * 48'(uy[47:24]));
      o1_6 <= sat32(ox5); o2_6 <= sat32(oy5);
      la6 <= la5; lb6 <= lb5; kind6 <= kind5;
    end
  end

  // stage 7: sum of squares
  logic [SQ_W-1:0] s7;
  value_t o1_7, o2_7, la7, lb7;
  logic [1:0] kind7;
  always_ff @(posedge clk) begin
    if (en) begin
      s7 <= sqx_ll + (sqx_hl << 25) + (sqx_hh << 48)
          + sqy_ll + (sqy_hl << 25) + (sqy_hh << 48);
      o1_7 <= o1_6; o2_7 <= o2_6; la7 <= la6; lb7 <= lb6; kind7 <= kind6;
    end
  end

  // square-root ladder, one result bit per stage (remainder form)
  logic [SQ_W-1:0]   rs_s [ROOT_W+1];
  logic [ROOT_W-1:0] rq_s [ROOT_W+1];
  logic [SQ_W+1:0]   rr_s [ROOT_W+1];
  value_t q1 [ROOT_W+1], q2 [ROOT_W+1], q3 [ROOT_W+1], q4 [ROOT_W+1];
  logic [1:0] qk [ROOT_W+1];
  always_comb begin
    rs_s[0] = s7; rq_s[0] = '0; rr_s[0] = '0;
    q1[0] = o1_7; q2[0] = o2_7; q3[0] = la7; q4[0] = lb7; qk[0] = kind7;
  end
  for (genvar i = 0; i < ROOT_W; i++) begin : g_rt
    logic [SQ_W+1:0] t, trial;
    always_comb begin
      t     = {rr_s[i][SQ_W-1:0], rs_s[i][SQ_W-1-2*i -: 2]};
      trial = {(SQ_W+2-ROOT_W-2)'(0), rq_s[i], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rs_s[i+1] <= rs_s[i];
        q1[i+1] <= q1[i]; q2[i+1] <= q2[i]; q3[i+1] <= q3[i];
        q4[i+1] <= q4[i]; qk[i+1] <= qk[i];
        if (t >= trial) begin
          rr_s[i+1] <= t - trial;
          rq_s[i+1] <= {rq_s[i][ROOT_W-2:0], 1'b1};
        end else begin
          rr_s[i+1] <= t;
          rq_s[i+1] <= {rq_s[i][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // final: round, select, saturate
  logic [ROOT_W:0] rnd;
  value_t r_sat;
  always_comb begin
    rnd   = {1'b0, rq_s[ROOT_W]} + ((rr_s[ROOT_W] > (SQ_W+2)'(rq_s[ROOT_W])) ? 1'b1 : 1'b0);
    r_sat = (rnd > (ROOT_W+1)'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : value_t'(rnd[31:0]);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= qk[ROOT_W];
      case (qk[ROOT_W])
        KIND_CIRCLE: m_tdata <= {r_sat, q2[ROOT_W], q1[ROOT_W]};
        KIND_LINE:   m_tdata <= {32'd0, q4[ROOT_W], q3[ROOT_W]};
        default:     m_tdata <= '0;
      endcase
    end
  end

  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == KIND_CIRCLE || m_tuser == KIND_LINE || m_tuser == KIND_DEGEN))
    else $error("bad kind");
  a_degen: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_DEGEN) |-> (m_tdata == '0))
    else $error("degenerate payload nonzero");
  a_line_c: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_LINE) |-> (m_tdata[95:64] == '0))
    else $error("line c nonzero");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled output changed");

endmodule
